// ===== hw/rtl/sfs_pkg.sv =====
// Shared types, constants and register codes for the sprite frame selector.
package sfs_pkg;

   // Default parameter values
   localparam int SPRITE_COUNT_DEF = 256;
   localparam int TIME_WIDTH_DEF   = 32;

   // Fixed field widths
   localparam int SPRITE_W = 8;
   localparam int COUNT_W  = SPRITE_W + 1;   // frame count, up to 256
   localparam int MOD_W    = SPRITE_W + 1;   // loop length, up to 2*255
   localparam int PERIOD_W = 32;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPRITE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_SPRITE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_MODE    = 2'd3;

   // Playback mode codes
   localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

   // Settings derived from the registers, shared by the divider and select stages
   typedef struct packed {
      logic [SPRITE_W-1:0] first;      // clamped first sprite
      logic [COUNT_W-1:0]  count;      // frames in the animation
      logic [SPRITE_W-1:0] last_off;   // count - 1
      logic [MOD_W-1:0]    mod_div;    // divisor for the frame remainder
      logic [PERIOD_W-1:0] period;     // nonzero frame period
      logic [MODE_W-1:0]   mode;
      logic                range_err;
   } cfg_type;

endpackage

// ===== hw/rtl/sfs_div_stage.sv =====
// One pipeline stage: a quotient bit of time / period and a remainder step of the frame count.
module sfs_div_stage #(
   parameter int DW = sfs_pkg::TIME_WIDTH_DEF - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfs_pkg::cfg_type               cfg,
   input  logic                           valid_i,
   input  logic [DW-1:0]                  dvd_i,
   input  logic [DW-1:0]                  quo_i,
   input  logic [sfs_pkg::PERIOD_W-1:0]   rem_i,
   input  logic [sfs_pkg::MOD_W-1:0]      mrem_i,
   input  logic                           mbit_i,
   output logic                           valid_o,
   output logic [DW-1:0]                  dvd_o,
   output logic [DW-1:0]                  quo_o,
   output logic [sfs_pkg::PERIOD_W-1:0]   rem_o,
   output logic [sfs_pkg::MOD_W-1:0]      mrem_o,
   output logic                           mbit_o
);

   logic                           valid_ff;
   logic [DW-1:0]                  dvd_ff, dvd_in;
   logic [DW-1:0]                  quo_ff, quo_in;
   logic [sfs_pkg::PERIOD_W-1:0]   rem_ff, rem_in;
   logic [sfs_pkg::MOD_W-1:0]      mrem_ff, mrem_in;
   logic                           mbit_ff, mbit_in;
   logic [sfs_pkg::PERIOD_W:0]     trial;
   logic [sfs_pkg::PERIOD_W:0]     trial_sub;
   logic [sfs_pkg::MOD_W:0]        mtrial;
   logic [sfs_pkg::MOD_W:0]        mtrial_sub;
   logic                           qbit;

   // Restoring division step on the next dividend bit
   always_comb begin
      trial     = {rem_i, dvd_i[DW-1]};
      trial_sub = trial - {1'b0, cfg.period};
      qbit      = (trial >= {1'b0, cfg.period});
      rem_in    = qbit ? trial_sub[sfs_pkg::PERIOD_W-1:0] : trial[sfs_pkg::PERIOD_W-1:0];
      dvd_in    = {dvd_i[DW-2:0], 1'b0};
      quo_in    = {quo_i[DW-2:0], qbit};
      mbit_in   = qbit;
   end

   // Fold the previous stage's quotient bit into the frame remainder
   always_comb begin
      mtrial     = {mrem_i, mbit_i};
      mtrial_sub = mtrial - {1'b0, cfg.mod_div};
      mrem_in    = (mtrial >= {1'b0, cfg.mod_div}) ? mtrial_sub[sfs_pkg::MOD_W-1:0]
                                                   : mtrial[sfs_pkg::MOD_W-1:0];
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      mrem_ff <= mrem_in;
      mbit_ff <= mbit_in;
   end

   assign valid_o = valid_ff;
   assign dvd_o   = dvd_ff;
   assign quo_o   = quo_ff;
   assign rem_o   = rem_ff;
   assign mrem_o  = mrem_ff;
   assign mbit_o  = mbit_ff;

endmodule

// ===== hw/rtl/sfs_select.sv =====
// Last two stages: final remainder step, playback mode and the registered result word.
module sfs_select #(
   parameter int DW = sfs_pkg::TIME_WIDTH_DEF - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfs_pkg::cfg_type               cfg,
   input  logic                           valid_i,
   input  logic [DW-1:0]                  quo_i,
   input  logic [sfs_pkg::MOD_W-1:0]      mrem_i,
   input  logic                           mbit_i,
   output logic                           valid_o,
   output logic [sfs_pkg::SPRITE_W-1:0]   sprite_index_o,
   output logic                           done_o,
   output logic                           range_error_o
);

   logic                           a_valid_ff;
   logic                           a_over_ff, a_over_in;
   logic [sfs_pkg::SPRITE_W-1:0]   a_frame_ff, a_frame_in;
   logic [sfs_pkg::MOD_W-1:0]      a_mrem_ff, a_mrem_in;
   logic [sfs_pkg::MOD_W:0]        mtrial;
   logic [sfs_pkg::MOD_W:0]        mtrial_sub;

   logic                           b_valid_ff;
   logic [sfs_pkg::SPRITE_W-1:0]   b_index_ff, b_index_in;
   logic                           b_done_ff, b_done_in;
   logic                           b_rerr_ff, b_rerr_in;
   logic [sfs_pkg::MOD_W-1:0]      ping_off;
   logic [sfs_pkg::SPRITE_W-1:0]   offset;

   // Stage A: last remainder step and the once-mode overflow compare
   always_comb begin
      mtrial     = {mrem_i, mbit_i};
      mtrial_sub = mtrial - {1'b0, cfg.mod_div};
      a_mrem_in  = (mtrial >= {1'b0, cfg.mod_div}) ? mtrial_sub[sfs_pkg::MOD_W-1:0]
                                                   : mtrial[sfs_pkg::MOD_W-1:0];
      a_over_in  = (quo_i >= DW'(cfg.count));
      a_frame_in = quo_i[sfs_pkg::SPRITE_W-1:0];
   end

   // Stage B: apply the playback mode
   always_comb begin
      ping_off  = {cfg.last_off, 1'b0} - a_mrem_ff;
      offset    = '0;
      b_done_in = 1'b0;
      b_rerr_in = cfg.range_err;
      if (!cfg.range_err) begin
         case (cfg.mode)
            sfs_pkg::MODE_ONCE: begin
               b_done_in = a_over_ff;
               offset    = a_over_ff ? cfg.last_off : a_frame_ff;
            end
            sfs_pkg::MODE_LOOP: begin
               offset = a_mrem_ff[sfs_pkg::SPRITE_W-1:0];
            end
            sfs_pkg::MODE_PING: begin
               if (cfg.last_off != '0) begin
                  if (a_mrem_ff <= {1'b0, cfg.last_off}) begin
                     offset = a_mrem_ff[sfs_pkg::SPRITE_W-1:0];
                  end else begin
                     offset = ping_off[sfs_pkg::SPRITE_W-1:0];
                  end
               end
            end
            default: begin
               offset = '0;
            end
         endcase
      end
      b_index_in = cfg.first + offset;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= valid_i;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      a_over_ff  <= a_over_in;
      a_frame_ff <= a_frame_in;
      a_mrem_ff  <= a_mrem_in;
      b_index_ff <= b_index_in;
      b_done_ff  <= b_done_in;
      b_rerr_ff  <= b_rerr_in;
   end

   assign valid_o        = b_valid_ff;
   assign sprite_index_o = b_index_ff;
   assign done_o         = b_done_ff;
   assign range_error_o  = b_rerr_ff;

endmodule

// ===== hw/rtl/sprite_frame_selector.sv =====
// Top level of the sprite frame selector: registers, input stage and the division pipeline.
//
//   Channel  Ports                                   Direction  Handshake
//   request  start, busy, req_time_now               in         start && !busy
//   result   rsp_valid, rsp_sprite_index,            out        rsp_valid, one cycle
//            rsp_done_res, rsp_range_error
//   config   csr_we, csr_index, csr_wdata            in         csr_we
//
// One word enters per cycle; busy stays low. A word taken passes through
// one input stage, TIME_WIDTH - 1 stages of the bit-per-stage divider,
// and two stages for remainder and mode, then appears as its result.
// Reset clears all valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module sprite_frame_selector #(
   parameter int SPRITE_COUNT = sfs_pkg::SPRITE_COUNT_DEF,
   parameter int TIME_WIDTH   = sfs_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [TIME_WIDTH-1:0]             req_time_now,
   output logic                              rsp_valid,
   output logic [sfs_pkg::SPRITE_W-1:0]      rsp_sprite_index,
   output logic                              rsp_done_res,
   output logic                              rsp_range_error,
   input  logic                              csr_we,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfs_pkg::PERIOD_W-1:0]      csr_wdata
);

   localparam int DW = TIME_WIDTH - 1;

   logic [sfs_pkg::SPRITE_W-1:0]   first_sprite_ff;
   logic [sfs_pkg::SPRITE_W-1:0]   last_sprite_ff;
   logic [sfs_pkg::PERIOD_W-1:0]   frame_period_ff;
   logic [sfs_pkg::MODE_W-1:0]     play_mode_ff;

   logic [sfs_pkg::SPRITE_W-1:0]   first_c;
   logic [sfs_pkg::SPRITE_W-1:0]   last_c;
   logic [sfs_pkg::COUNT_W-1:0]    count_c;
   sfs_pkg::cfg_type               cfg;

   logic                           in_valid_ff;
   logic [DW-1:0]                  in_dvd_ff, in_dvd_in;

   logic                           valid_w [0:DW];
   logic [DW-1:0]                  dvd_w   [0:DW];
   logic [DW-1:0]                  quo_w   [0:DW];
   logic [sfs_pkg::PERIOD_W-1:0]   rem_w   [0:DW];
   logic [sfs_pkg::MOD_W-1:0]      mrem_w  [0:DW];
   logic                           mbit_w  [0:DW];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_sprite_ff <= '0;
         last_sprite_ff  <= '0;
         frame_period_ff <= 32'd65536;
         play_mode_ff    <= sfs_pkg::MODE_ONCE;
      end else if (csr_we) begin
         case (csr_index)
            sfs_pkg::CSR_FIRST_SPRITE: first_sprite_ff <= csr_wdata[sfs_pkg::SPRITE_W-1:0];
            sfs_pkg::CSR_LAST_SPRITE:  last_sprite_ff  <= csr_wdata[sfs_pkg::SPRITE_W-1:0];
            sfs_pkg::CSR_FRAME_PERIOD: frame_period_ff <= csr_wdata;
            sfs_pkg::CSR_PLAY_MODE:    play_mode_ff    <= csr_wdata[sfs_pkg::MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Derive the shared settings: clamp sprites, frame count, remainder divisor
   always_comb begin
      first_c = (32'(first_sprite_ff) >= 32'(SPRITE_COUNT)) ?
                sfs_pkg::SPRITE_W'(SPRITE_COUNT - 1) : first_sprite_ff;
      last_c  = (32'(last_sprite_ff) >= 32'(SPRITE_COUNT)) ?
                sfs_pkg::SPRITE_W'(SPRITE_COUNT - 1) : last_sprite_ff;
      count_c = {1'b0, last_c} - {1'b0, first_c} + 9'd1;

      cfg.first     = first_c;
      cfg.count     = count_c;
      cfg.last_off  = last_c - first_c;
      cfg.period    = (frame_period_ff == '0) ? 32'd1 : frame_period_ff;
      cfg.mode      = play_mode_ff;
      cfg.range_err = (last_c < first_c);
      if (cfg.range_err) begin
         cfg.mod_div = 9'd1;
      end else if (play_mode_ff == sfs_pkg::MODE_PING && last_c != first_c) begin
         cfg.mod_div = {cfg.last_off, 1'b0};
      end else begin
         cfg.mod_div = count_c;
      end
   end

   // Input stage: negative time counts as frame zero
   assign busy      = 1'b0;
   assign in_dvd_in = req_time_now[TIME_WIDTH-1] ? '0 : req_time_now[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_dvd_ff <= in_dvd_in;
   end

   assign valid_w[0] = in_valid_ff;
   assign dvd_w[0]   = in_dvd_ff;
   assign quo_w[0]   = '0;
   assign rem_w[0]   = '0;
   assign mrem_w[0]  = '0;
   assign mbit_w[0]  = 1'b0;

   // Divider chain: one quotient bit per stage
   for (genvar i = 0; i < DW; i++) begin : g_div
      sfs_div_stage #(
         .DW (DW)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg),
         .valid_i (valid_w[i]),
         .dvd_i   (dvd_w[i]),
         .quo_i   (quo_w[i]),
         .rem_i   (rem_w[i]),
         .mrem_i  (mrem_w[i]),
         .mbit_i  (mbit_w[i]),
         .valid_o (valid_w[i+1]),
         .dvd_o   (dvd_w[i+1]),
         .quo_o   (quo_w[i+1]),
         .rem_o   (rem_w[i+1]),
         .mrem_o  (mrem_w[i+1]),
         .mbit_o  (mbit_w[i+1])
      );
   end

   // Mode selection and output word
   sfs_select #(
      .DW (DW)
   ) u_select (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .valid_i        (valid_w[DW]),
      .quo_i          (quo_w[DW]),
      .mrem_i         (mrem_w[DW]),
      .mbit_i         (mbit_w[DW]),
      .valid_o        (rsp_valid),
      .sprite_index_o (rsp_sprite_index),
      .done_o         (rsp_done_res),
      .range_error_o  (rsp_range_error)
   );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the sprite frame selector: directed corners, then random configs and times.
`timescale 1ns / 1ps

module tb_top;

   localparam int TW          = sfs_pkg::TIME_WIDTH_DEF;
   localparam int SC          = sfs_pkg::SPRITE_COUNT_DEF;
   localparam int LATENCY     = TW + 2;
   localparam int QUIET_LIMIT = 1000;
   localparam logic [sfs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [sfs_pkg::SPRITE_W-1:0] sprite;
      logic                         done;
      logic                         range_err;
   } sprite_pick_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [TW-1:0]                 req_time_now = '0;
   logic                          rsp_valid;
   logic [sfs_pkg::SPRITE_W-1:0]  rsp_sprite_index;
   logic                          rsp_done_res;
   logic                          rsp_range_error;
   logic                          csr_we = 1'b0;
   logic [sfs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sfs_pkg::PERIOD_W-1:0]  csr_wdata = '0;

   // Animation settings as last written, used to predict each pick
   logic [sfs_pkg::SPRITE_W-1:0]  anim_first  = '0;
   logic [sfs_pkg::SPRITE_W-1:0]  anim_last   = '0;
   logic [sfs_pkg::PERIOD_W-1:0]  anim_period = 32'd65536;
   logic [sfs_pkg::MODE_W-1:0]    anim_mode   = sfs_pkg::MODE_ONCE;

   sprite_pick_type pending_picks[$];
   sprite_pick_type oldest_pick;
   int              idle_pct      = 0;
   int              words_sent    = 0;
   int              picks_checked = 0;
   int              settings_used = 0;
   int              fails         = 0;
   int              quiet_cycles  = 0;

   sprite_frame_selector #(
      .SPRITE_COUNT(SC),
      .TIME_WIDTH  (TW)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_time_now    (req_time_now),
      .rsp_valid       (rsp_valid),
      .rsp_sprite_index(rsp_sprite_index),
      .rsp_done_res    (rsp_done_res),
      .rsp_range_error (rsp_range_error),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the sprite shown at time t under the current animation settings
   function automatic sprite_pick_type pick_sprite(logic [TW-1:0] t);
      longint unsigned lo, hi, per, n, frame, span, phase, idx;
      sprite_pick_type r;
      lo  = (anim_first >= SC) ? 64'(SC - 1) : 64'(anim_first);
      hi  = (anim_last >= SC) ? 64'(SC - 1) : 64'(anim_last);
      per = (anim_period == 0) ? 64'd1 : 64'(anim_period);
      idx = lo;
      r.done = 1'b0;
      r.range_err = 1'b0;
      if (hi < lo) begin
         r.range_err = 1'b1;
      end else begin
         n     = hi - lo + 1;
         frame = t[TW-1] ? 64'd0 : 64'(t) / per;
         case (anim_mode)
            sfs_pkg::MODE_ONCE: begin
               r.done = (frame >= n);
               idx = lo + ((frame > n - 1) ? n - 1 : frame);
            end
            sfs_pkg::MODE_LOOP: begin
               idx = lo + frame % n;
            end
            sfs_pkg::MODE_PING: begin
               if (n > 1) begin
                  span  = n - 1;
                  phase = frame % (2 * span);
                  idx   = (phase <= span) ? lo + phase : lo + 2 * span - phase;
               end
            end
            default: ;
         endcase
      end
      r.sprite = sfs_pkg::SPRITE_W'(idx);
      return r;
   endfunction

   // Pick a time inside one of the first 4 * frames + 3 frame periods most of the time
   function automatic logic [TW-1:0] rand_time(longint unsigned frames, longint unsigned per);
      int unsigned     sel;
      longint unsigned val;
      logic [TW-1:0]   t;
      sel = $urandom_range(9);
      if (sel < 6) begin
         val = 64'($urandom_range(32'(4 * frames + 2))) * per + 64'($urandom % per);
         if (val > 64'h7FFF_FFFF) val = 64'($urandom_range(32'h7FFF_FFFF));
         t = TW'(val);
      end else if (sel < 8) begin
         t = TW'($urandom);
      end else if (sel == 8) begin
         t = TW'($urandom);
         t[TW-1] = 1'b1;
      end else begin
         case ($urandom_range(3))
            0:       t = '0;
            1:       t = {1'b0, {(TW-1){1'b1}}};
            2:       t = {1'b1, {(TW-1){1'b0}}};
            default: t = '1;
         endcase
      end
      return t;
   endfunction

   // Fill the bits above a narrow register with noise
   function automatic logic [sfs_pkg::PERIOD_W-1:0] with_noise(
      logic [sfs_pkg::PERIOD_W-1:0] value, int keep);
      logic [sfs_pkg::PERIOD_W-1:0] noise;
      noise = $urandom;
      return ((noise >> keep) << keep) | value;
   endfunction

   // Send one word, record its pick, then idle at random
   task automatic send_time(input logic [TW-1:0] t);
      int gap;
      start <= 1'b1;
      req_time_now <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_picks.insert(pending_picks.size(), pick_sprite(t));
      words_sent++;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         req_time_now <= TW'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and wait for every pending pick to come back
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sfs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfs_pkg::PERIOD_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write all four registers once the pipeline is empty
   task automatic load_animation(input logic [sfs_pkg::PERIOD_W-1:0] first_raw,
                                 input logic [sfs_pkg::PERIOD_W-1:0] last_raw,
                                 input logic [sfs_pkg::PERIOD_W-1:0] period_raw,
                                 input logic [sfs_pkg::PERIOD_W-1:0] mode_raw);
      wait_idle();
      write_reg(sfs_pkg::CSR_FIRST_SPRITE, first_raw);
      write_reg(sfs_pkg::CSR_LAST_SPRITE, last_raw);
      write_reg(sfs_pkg::CSR_FRAME_PERIOD, period_raw);
      write_reg(sfs_pkg::CSR_PLAY_MODE, mode_raw);
      csr_we <= 1'b0;
      anim_first  = first_raw[sfs_pkg::SPRITE_W-1:0];
      anim_last   = last_raw[sfs_pkg::SPRITE_W-1:0];
      anim_period = period_raw;
      anim_mode   = mode_raw[sfs_pkg::MODE_W-1:0];
      settings_used++;
   endtask

   // Reset values: a one-frame animation in once mode
   task automatic test_reset_values();
      send_time(TW'(0));
      send_time(TW'(65536));
      send_time(TW'(32'hFFFF_0000));
   endtask

   task automatic test_once_mode();
      load_animation(10, 13, 65536, sfs_pkg::MODE_ONCE);
      send_time(TW'(0));
      send_time(TW'(65535));
      send_time(TW'(3 * 65536));
      send_time(TW'(4 * 65536));
      send_time(TW'(32'h7FFF_FFFF));
      send_time(TW'(32'hFFFF_FFFF));
   endtask

   task automatic test_loop_mode();
      load_animation(10, 13, 65536, sfs_pkg::MODE_LOOP);
      send_time(TW'(5 * 65536 + 7));
      send_time(TW'(32'h7FFF_FFFF));
      send_time(TW'(32'h8000_0000));
   endtask

   // Walk across the turn at the last frame and back to the first
   task automatic test_pingpong_mode();
      load_animation(20, 23, 1, sfs_pkg::MODE_PING);
      for (int i = 3; i <= 7; i++) send_time(TW'(i));
   endtask

   task automatic test_corner_cases();
      // last below first
      load_animation(200, 100, 65536, sfs_pkg::MODE_LOOP);
      send_time(TW'(5 * 65536));
      // zero period counts as one
      load_animation(0, 255, 0, sfs_pkg::MODE_LOOP);
      send_time(TW'(300));
      // unused mode holds the first frame
      load_animation(5, 9, 1, MODE_UNUSED);
      send_time(TW'(32'h0012_3456));
      // single frame in ping-pong
      load_animation(200, 200, 1, sfs_pkg::MODE_PING);
      send_time(TW'(12345));
      // widest range, longest period
      load_animation(0, 255, 32'hFFFF_FFFF, sfs_pkg::MODE_LOOP);
      send_time(TW'(32'h7FFF_FFFF));
      // top sprite, single frame once mode past its end
      load_animation(255, 255, 1, sfs_pkg::MODE_ONCE);
      send_time(TW'(1));
   endtask

   // Random settings and times under each idle plan
   task automatic test_random_traffic();
      int                           idle_plan[4];
      logic [sfs_pkg::SPRITE_W-1:0] f, l;
      logic [sfs_pkg::PERIOD_W-1:0] per;
      logic [sfs_pkg::MODE_W-1:0]   m;
      int                           sel;
      int                           step;
      longint unsigned              frames, eff_per;
      idle_plan = '{0, 48, 0, 16};
      foreach (idle_plan[p]) begin
         idle_pct = idle_plan[p];
         for (int c = 0; c < 5; c++) begin
            f = sfs_pkg::SPRITE_W'($urandom_range(255));
            sel = $urandom_range(99);
            step = $urandom_range(7);
            if (sel < 8 && f > 0) l = sfs_pkg::SPRITE_W'($urandom_range(32'(f) - 1));
            else if (sel < 30) l = sfs_pkg::SPRITE_W'($urandom_range(255, 32'(f)));
            else l = (32'(f) + step > 255) ? 8'd255 : sfs_pkg::SPRITE_W'(32'(f) + step);
            case ($urandom_range(9))
               0:       per = '0;
               1, 2:    per = $urandom_range(1, 16);
               7:       per = $urandom;
               8:       per = '1;
               9:       per = $urandom_range(1, 1000);
               default: per = $urandom_range(1, 16) << 14;
            endcase
            m = ($urandom_range(19) == 0) ? MODE_UNUSED
                                          : sfs_pkg::MODE_W'($urandom_range(2));
            load_animation(with_noise(32'(f), sfs_pkg::SPRITE_W),
                           with_noise(32'(l), sfs_pkg::SPRITE_W), per,
                           with_noise(32'(m), sfs_pkg::MODE_W));
            frames  = (l >= f) ? 64'(l) - 64'(f) + 64'd1 : 64'd1;
            eff_per = (per == 0) ? 64'd1 : 64'(per);
            for (int i = 0; i < 25; i++) send_time(rand_time(frames, eff_per));
         end
      end
   endtask

   // Compare each result word with the oldest pending pick
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_picks.size() == 0) begin
            $error("unexpected result word: sprite_index %0d", rsp_sprite_index);
            fails++;
         end else begin
            oldest_pick = pending_picks.pop_front();
            picks_checked++;
            if (rsp_sprite_index !== oldest_pick.sprite) begin
               $error("sprite_index: expected %0d, got %0d", oldest_pick.sprite,
                      rsp_sprite_index);
               fails++;
            end
            if (rsp_done_res !== oldest_pick.done) begin
               $error("done_res: expected %0d, got %0d", oldest_pick.done, rsp_done_res);
               fails++;
            end
            if (rsp_range_error !== oldest_pick.range_err) begin
               $error("range_error: expected %0d, got %0d", oldest_pick.range_err,
                      rsp_range_error);
               fails++;
            end
         end
      end
   end

   // Watchdog: stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** sprite_frame_selector: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_once_mode();
      test_loop_mode();
      test_pingpong_mode();
      test_corner_cases();
      test_random_traffic();
      wait_idle();
      repeat (LATENCY + 2) @(posedge clock);
      $display("Covered once, loop, ping-pong and unused modes over %0d register settings,",
               settings_used);
      $display("with %0d time words sent and %0d result words checked.", words_sent,
               picks_checked);
      if (fails == 0) begin
         $display("** sprite_frame_selector: PASSED **");
      end else begin
         $display("** sprite_frame_selector: FAILED **");
      end
      $finish;
   end

endmodule
